@@ rtl/ida_pkg.sv @@
package ida_pkg;

  localparam int NUM_IDS   = 256;
  localparam int WORD_BITS = 64;

  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MEM_BITS  = 1 << BIT_W;
  localparam int NUM_WORDS = (NUM_IDS + MEM_BITS - 1) / MEM_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = BIT_W + WIDX_W;
  localparam int ID_W      = 16;
  localparam int LIM_W     = ID_W + 1;

  localparam logic [ID_W-1:0]   RESET_BASE = 16'd300;
  localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(NUM_WORDS - 1);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_IN_USE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

@@ rtl/ida_ram.sv @@
module ida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/id_bitmap_allocator.sv @@
// release and reserve read the bitmap word, update it in S_RMW and pass the result
// on through S_OUT; allocate scans one word per cycle in S_SCAN up to the first free id
// or the last word, at most NUM_WORDS words, in the bitmap memory (one read, one write port)
// a new item is taken only in S_IDLE, once the last result was loaded for output
// reset: synchronous, clears the bitmap through per-word valid bits, base_id to 300
module id_bitmap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pid
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pid_res
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int BIT_W    = ida_pkg::BIT_W;
  localparam int MEM_BITS = ida_pkg::MEM_BITS;
  localparam int WIDX_W   = ida_pkg::WIDX_W;
  localparam int IDX_W    = ida_pkg::IDX_W;
  localparam int ID_W     = ida_pkg::ID_W;
  localparam int LIM_W    = ida_pkg::LIM_W;

  ida_pkg::state_t  state_r, state_nxt;
  ida_pkg::op_t     op_r;
  logic [ID_W-1:0]  pid_r;
  logic [IDX_W-1:0] k_r;
  logic             in_range_r;
  logic [WIDX_W-1:0] scan_w_r, scan_w_nxt;
  logic [WIDX_W-1:0] rd_addr_r, rd_addr;
  logic [ida_pkg::NUM_WORDS-1:0] valid_r;
  logic [ID_W-1:0]  base_r;
  logic [ID_W-1:0]  res_pid_r, res_pid_nxt;
  ida_pkg::status_t res_status_r, res_status_nxt;
  logic             out_tvalid_r;
  logic [ID_W-1:0]  out_pid_r;
  ida_pkg::status_t out_status_r;
  logic             out_load;

  logic             accept;
  ida_pkg::op_t     in_op;
  logic [ID_W-1:0]  diff;
  logic             in_range;
  logic             wr_en;
  logic [MEM_BITS-1:0] wr_data;
  logic [MEM_BITS-1:0] rd_data;
  logic [MEM_BITS-1:0] cur_word;
  logic [MEM_BITS-1:0] bit_sel;
  logic [LIM_W-1:0] avail;
  logic [LIM_W-1:0] eff_lim;
  logic [LIM_W-1:0] w_lo;
  logic [LIM_W-1:0] w_hi;
  logic [MEM_BITS-1:0] usable;
  logic [MEM_BITS-1:0] busy;
  logic             found;
  logic [BIT_W-1:0] ff_idx;
  logic [ID_W-1:0]  alloc_id;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = (state_r == ida_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_op     = ida_pkg::op_t'(in_tuser);
  assign diff      = in_tdata - base_r;
  assign in_range  = (in_tdata >= base_r) && ({1'b0, diff} < LIM_W'(ida_pkg::NUM_IDS));

  assign cur_word = valid_r[rd_addr_r] ? rd_data : '0;
  assign bit_sel  = MEM_BITS'(1) << k_r[BIT_W-1:0];

  // ids that are past the top of the id space or past NUM_IDS are never free
  assign avail   = {1'b1, {ID_W{1'b0}}} - {1'b0, base_r};
  assign eff_lim = (avail > LIM_W'(ida_pkg::NUM_IDS)) ? LIM_W'(ida_pkg::NUM_IDS) : avail;
  assign w_lo    = LIM_W'({scan_w_r, {BIT_W{1'b0}}});
  assign w_hi    = w_lo + LIM_W'(MEM_BITS);

  always_comb begin
    if (eff_lim >= w_hi) begin
      usable = '1;
    end else if (eff_lim <= w_lo) begin
      usable = '0;
    end else begin
      usable = ~({MEM_BITS{1'b1}} << eff_lim[BIT_W-1:0]);
    end
  end

  assign busy = cur_word | ~usable;

  always_comb begin
    found  = 1'b0;
    ff_idx = '0;
    for (int i = MEM_BITS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found  = 1'b1;
        ff_idx = BIT_W'(i);
      end
    end
  end

  assign alloc_id = base_r + ID_W'({scan_w_r, ff_idx});

  always_comb begin
    state_nxt      = state_r;
    scan_w_nxt     = scan_w_r;
    rd_addr        = rd_addr_r;
    wr_en          = 1'b0;
    wr_data        = cur_word;
    res_pid_nxt    = res_pid_r;
    res_status_nxt = res_status_r;
    out_load       = 1'b0;
    unique case (state_r)
      ida_pkg::S_IDLE: begin
        if (accept) begin
          if (in_op == ida_pkg::OP_ALLOC) begin
            rd_addr    = '0;
            scan_w_nxt = '0;
            state_nxt  = ida_pkg::S_SCAN;
          end else begin
            rd_addr   = diff[IDX_W-1:BIT_W];
            state_nxt = ida_pkg::S_RMW;
          end
        end
      end
      ida_pkg::S_RMW: begin
        res_pid_nxt    = pid_r;
        res_status_nxt = ida_pkg::ST_RANGE;
        if (in_range_r) begin
          unique case (op_r)
            ida_pkg::OP_RELEASE: begin
              wr_en          = 1'b1;
              wr_data        = cur_word & ~bit_sel;
              res_status_nxt = ida_pkg::ST_OK;
            end
            ida_pkg::OP_RESERVE: begin
              if ((cur_word & bit_sel) != '0) begin
                res_status_nxt = ida_pkg::ST_IN_USE;
              end else begin
                wr_en          = 1'b1;
                wr_data        = cur_word | bit_sel;
                res_status_nxt = ida_pkg::ST_OK;
              end
            end
            default: begin
              res_status_nxt = ida_pkg::ST_RANGE;
            end
          endcase
        end
        state_nxt = ida_pkg::S_OUT;
      end
      ida_pkg::S_SCAN: begin
        if (found) begin
          wr_en          = 1'b1;
          wr_data        = cur_word | (MEM_BITS'(1) << ff_idx);
          res_pid_nxt    = alloc_id;
          res_status_nxt = ida_pkg::ST_OK;
          state_nxt      = ida_pkg::S_OUT;
        end else if (scan_w_r == ida_pkg::LAST_WORD) begin
          res_pid_nxt    = '0;
          res_status_nxt = ida_pkg::ST_NONE_FREE;
          state_nxt      = ida_pkg::S_OUT;
        end else begin
          scan_w_nxt = scan_w_r + WIDX_W'(1);
          rd_addr    = scan_w_r + WIDX_W'(1);
        end
      end
      ida_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ida_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ida_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ida_pkg::S_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      base_r       <= ida_pkg::RESET_BASE;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        valid_r[rd_addr_r] <= 1'b1;
      end
      out_tvalid_r <= out_load | (out_tvalid_r & ~out_tready);
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_op;
      pid_r      <= in_tdata;
      k_r        <= diff[IDX_W-1:0];
      in_range_r <= in_range;
    end
    scan_w_r     <= scan_w_nxt;
    rd_addr_r    <= rd_addr;
    res_pid_r    <= res_pid_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_pid_r    <= res_pid_r;
      out_status_r <= res_status_r;
    end
  end

  ida_ram #(
    .WIDTH (MEM_BITS),
    .DEPTH (ida_pkg::NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_addr_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pid_r;
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ida_pkg::S_RMW || state_r == ida_pkg::S_SCAN))
    else $error("bitmap written outside a read-modify-write");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ida_pkg::S_SCAN) |-> (scan_w_r <= ida_pkg::LAST_WORD))
    else $error("scan ran past the last bitmap word");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ida_pkg::S_IDLE))
    else $error("transfer accepted without starting work");

  a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ida_pkg::S_OUT && op_r == ida_pkg::OP_ALLOC &&
     res_status_r == ida_pkg::ST_OK) |-> (res_pid_r >= base_r))
    else $error("allocated id below base");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned ID_MAX    = 65535;
  localparam int unsigned BASE_MAX  = 65279;

  typedef struct packed {
    logic [15:0]      pid_res;
    ida_pkg::status_t status;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // pid
  logic [1:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // pid_res
  logic [1:0]  out_tuser;  // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  bit [ida_pkg::NUM_IDS-1:0] id_map;
  int unsigned      base_reg;
  grant_t           awaited_grants[$];
  int               errors;
  int               n_items;
  int               n_base_writes;
  int               status_seen[4];
  bit               idling_on;

  id_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // expected grant for one request, updating the bitmap copy
  function automatic grant_t grant_for(logic [1:0] op, logic [15:0] pid);
    grant_t      g;
    int unsigned k;
    bit          hit;
    g.pid_res = pid;
    g.status  = ida_pkg::ST_RANGE;
    hit = (pid >= base_reg) && (pid - base_reg < ida_pkg::NUM_IDS);
    k = pid - base_reg;
    case (op)
      ida_pkg::OP_ALLOC: begin
        g.pid_res = '0;
        g.status  = ida_pkg::ST_NONE_FREE;
        for (int i = 0; i < ida_pkg::NUM_IDS; i++) begin
          if (base_reg + i > ID_MAX) break;
          if (!id_map[i]) begin
            id_map[i] = 1'b1;
            g.pid_res = 16'(base_reg + i);
            g.status  = ida_pkg::ST_OK;
            break;
          end
        end
      end
      ida_pkg::OP_RELEASE: begin
        if (hit) begin
          id_map[k] = 1'b0;
          g.status  = ida_pkg::ST_OK;
        end
      end
      ida_pkg::OP_RESERVE: begin
        if (hit) begin
          if (id_map[k]) begin
            g.status = ida_pkg::ST_IN_USE;
          end else begin
            id_map[k] = 1'b1;
            g.status  = ida_pkg::ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    status_seen[g.status]++;
    return g;
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] pid);
    while (idling_on && $urandom_range(99) < 7) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = pid;
    do @(posedge clk); while (!in_tready);
    awaited_grants.push_back(grant_for(op, pid));
    n_items++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (awaited_grants.size() != 0) @(negedge clk);
    repeat (ida_pkg::NUM_WORDS + 4) @(negedge clk);
  endtask

  task automatic write_base(logic [15:0] value);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    base_reg = value;
    n_base_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_pid();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return 16'(base_reg + $urandom_range(ida_pkg::NUM_IDS - 1));
    if (r < 88) return 16'(base_reg - 1);
    if (r < 90) return 16'(base_reg + ida_pkg::NUM_IDS);
    return 16'($urandom_range(ID_MAX));
  endfunction

  task automatic test_directed();
    // reset base, edges of the range, repeats and unused code
    send_item(ida_pkg::OP_ALLOC, 16'hFFFF);
    send_item(ida_pkg::OP_ALLOC, 16'h0000);
    send_item(ida_pkg::OP_RESERVE, 16'd301);
    send_item(ida_pkg::OP_RESERVE, 16'd302);
    send_item(ida_pkg::OP_RESERVE, 16'd555);
    send_item(ida_pkg::OP_RESERVE, 16'd556);
    send_item(ida_pkg::OP_RELEASE, 16'd299);
    send_item(ida_pkg::OP_RELEASE, 16'd301);
    send_item(ida_pkg::OP_RELEASE, 16'd301);
    send_item(ida_pkg::OP_ALLOC, 16'h0000);
    send_item(OP_UNUSED, 16'd400);
    send_item(ida_pkg::OP_RELEASE, 16'h0000);
    send_item(ida_pkg::OP_RESERVE, 16'hFFFF);
    write_base(16'd0);
    send_item(ida_pkg::OP_ALLOC, 16'h5555);
    send_item(ida_pkg::OP_RESERVE, 16'd0);
    send_item(ida_pkg::OP_RESERVE, 16'd255);
    send_item(ida_pkg::OP_RESERVE, 16'd256);
    send_item(ida_pkg::OP_RELEASE, 16'd0);
    send_item(ida_pkg::OP_ALLOC, 16'hAAAA);
    write_base(16'(BASE_MAX));
    send_item(ida_pkg::OP_RESERVE, 16'd65534);
    send_item(ida_pkg::OP_RESERVE, 16'hFFFF);
    send_item(ida_pkg::OP_RELEASE, 16'd65278);
    send_item(ida_pkg::OP_ALLOC, 16'h0000);
    send_item(OP_UNUSED, 16'hAAAA);
  endtask

  task automatic test_exhaustion();
    int unsigned k;
    write_base(16'($urandom_range(BASE_MAX)));
    repeat (ida_pkg::NUM_IDS - $countones(id_map) + 3) begin
      send_item(ida_pkg::OP_ALLOC, 16'($urandom_range(ID_MAX)));
    end
    k = $urandom_range(ida_pkg::NUM_IDS - 1);
    send_item(ida_pkg::OP_RESERVE, 16'(base_reg + k));
    repeat (20) begin
      send_item(ida_pkg::OP_RELEASE, 16'(base_reg + $urandom_range(ida_pkg::NUM_IDS - 1)));
    end
    repeat (24) send_item(ida_pkg::OP_ALLOC, 16'($urandom_range(ID_MAX)));
  endtask

  task automatic run_mix(int unsigned alloc_pct, int unsigned count);
    int unsigned r;
    logic [1:0]  op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < alloc_pct) begin
        op = ida_pkg::OP_ALLOC;
      end else if (r < alloc_pct + (100 - alloc_pct) / 2) begin
        op = ida_pkg::OP_RELEASE;
      end else begin
        op = ida_pkg::OP_RESERVE;
      end
      if ($urandom_range(99) == 0) op = OP_UNUSED;
      send_item(op, pick_pid());
    end
  endtask

  task automatic test_random();
    write_base(16'($urandom_range(BASE_MAX)));
    run_mix(60, 250);
    write_base(16'd0);
    run_mix(30, 250);
    // long stretch with no idling on either side
    idling_on = 1'b0;
    write_base(16'(BASE_MAX));
    run_mix(65, 250);
    idling_on = 1'b1;
    write_base(ida_pkg::RESET_BASE);
    run_mix(35, 250);
    write_base(16'($urandom_range(BASE_MAX)));
    run_mix(55, 250);
  endtask

  always @(negedge clk) begin
    out_tready = !(idling_on && $urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_grants.size() == 0) begin
        $error("unexpected transfer: pid_res %0d status %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = awaited_grants.pop_front();
        if (out_tdata !== want.pid_res) begin
          $error("pid_res: expected %0d, got %0d", want.pid_res, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ida_pkg::OP_ALLOC;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    idling_on  = 1'b1;
    id_map     = '0;
    base_reg   = ida_pkg::RESET_BASE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_exhaustion();
    test_random();
    settle();
    $display("%0d requests over %0d base settings including 0 and %0d", n_items,
             n_base_writes, BASE_MAX);
    $display("granted %0d, none free %0d, out of range %0d, already in use %0d",
             status_seen[ida_pkg::ST_OK], status_seen[ida_pkg::ST_NONE_FREE],
             status_seen[ida_pkg::ST_RANGE], status_seen[ida_pkg::ST_IN_USE]);
    if (errors == 0 && awaited_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", awaited_grants.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ida_pkg.sv
rtl/ida_ram.sv
rtl/id_bitmap_allocator.sv
test/testbench.sv
